### design/pfa_pkg.sv
// Shared types and codes for the page and frame allocator.
// No dependencies; pfa_frame_stack and the top level refer to it by scoped names.
package pfa_pkg;

  localparam int FRAME_W = 12;
  localparam int PAGE_W  = 12;

  // Request kinds carried in the input tuser.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_GIVE  = 2'd2;
  localparam logic [1:0] OP_MAP   = 2'd3;

  // Result status codes carried in the output tuser.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_PAGE     = 3'd1;
  localparam logic [2:0] ST_NO_FRAME    = 3'd2;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;

  // Non-present bits of a page entry; present lives in the bitmap.
  typedef struct packed {
    logic               user;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic               push;
    logic [FRAME_W-1:0] wdata;
    logic               rd;
    logic               pop;
  } stk_cmd_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [FRAME_W-1:0] rdata;
  } stk_stat_t;

endpackage

### design/pfa_find_zero.sv
// Finds the lowest clear bit of one bitmap row; this is the unit the scan reuses.
// Depends on nothing but its parameter.
module pfa_find_zero #(
  parameter int ROW_W = 64
) (
  input  logic [ROW_W-1:0]         row,
  output logic                     found,
  output logic [$clog2(ROW_W)-1:0] idx
);

  localparam int BW = $clog2(ROW_W);

  logic [ROW_W-1:0] oh;

  // Adding one carries through the low ones and lands on the lowest zero.
  assign oh    = ~row & (row + ROW_W'(1));
  assign found = ~&row;

  always_comb begin
    idx = '0;
    for (int b = 0; b < ROW_W; b++) begin
      if (oh[b]) begin
        idx = idx | BW'(b);
      end
    end
  end

endmodule

### design/pfa_frame_stack.sv
// Stack of free physical frames with a registered read of the top entry.
// Uses pfa_pkg for the command and status structs.
module pfa_frame_stack #(
  parameter int FRAMES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfa_pkg::stk_cmd_t    cmd,
  output pfa_pkg::stk_stat_t   stat
);

  localparam int CW  = $clog2(FRAMES + 1);
  localparam int FAW = $clog2(FRAMES);

  logic [pfa_pkg::FRAME_W-1:0] mem [FRAMES];
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               cnt_nxt;
  logic [CW-1:0]               top_w;
  logic [pfa_pkg::FRAME_W-1:0] rdata_r;
  logic                        full_w;
  logic                        empty_w;

  assign full_w  = (cnt_r == CW'(FRAMES));
  assign empty_w = (cnt_r == '0);
  assign top_w   = cnt_r - CW'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push && !full_w) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop && !empty_w) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full_w) begin
      mem[cnt_r[FAW-1:0]] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[top_w[FAW-1:0]];
    end
  end

  assign stat.empty = empty_w;
  assign stat.full  = full_w;
  assign stat.rdata = rdata_r;

endmodule

### design/page_and_frame_allocator.sv
// Top level of the page and frame allocator: sequencer, present bitmap and entry table.
// Depends on pfa_pkg, pfa_find_zero and pfa_frame_stack.
//
//  port group  | dir | tdata                               | tuser
//  in_*        | in  | page_index[11:0], frame_number[23:12] | opcode[1:0], is_kernel[2]
//  out_*       | out | page_out[11:0], frame_out[23:12]      | status[2:0]
//
// Give goes straight to the response state, free and map through the RMW state,
// alloc scans, then pops a frame if any; the scan reads one bitmap row (64 pages at
// default size) per cycle through a single find-zero unit. After reset a
// clearing pass writes every bitmap row with in_tready low. One item is in work
// at a time; a finished result waits in the output register while the next item
// is accepted, and the sequencer holds a new result until that register is free.
module page_and_frame_allocator #(
  parameter int PAGES  = 4096,
  parameter int FRAMES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // page_index[11:0], frame_number[23:12]
  input  logic [2:0]  in_tuser,   // opcode[1:0], is_kernel[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // page_out[11:0], frame_out[23:12]
  output logic [2:0]  out_tuser   // status[2:0]
);

  localparam int ROW_W = (PAGES >= 128) ? 64 : 8;
  localparam int BW    = $clog2(ROW_W);
  localparam int ROWS  = (PAGES + ROW_W - 1) / ROW_W;
  localparam int RW    = $clog2(ROWS);
  localparam int PG_W  = BW + RW;
  localparam int LAST_VALID = PAGES - (ROWS - 1) * ROW_W;
  localparam logic [ROW_W-1:0] LAST_PAD = {ROW_W{1'b1}} << LAST_VALID;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_RMW   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam int FW = pfa_pkg::FRAME_W;

  // Input fields.
  logic [1:0]    in_op;
  logic          in_kern;
  logic [11:0]   in_page;
  logic [FW-1:0] in_frame;
  logic [PG_W-1:0] in_pg;
  logic          page_ok;

  assign in_op    = in_tuser[1:0];
  assign in_kern  = in_tuser[2];
  assign in_page  = in_tdata[11:0];
  assign in_frame = in_tdata[23:12];
  assign in_pg    = PG_W'(in_page);
  assign page_ok  = ({20'd0, in_page} < 32'(PAGES));

  // Sequencer state.
  logic [2:0]      state_r, state_nxt;
  logic [1:0]      op_r, op_nxt;
  logic            kern_r, kern_nxt;
  logic [PG_W-1:0] pg_r, pg_nxt;
  logic [FW-1:0]   frm_r, frm_nxt;
  logic [RW:0]     issue_r, issue_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [RW-1:0]   chk_row_r, chk_row_nxt;
  logic [RW-1:0]   clr_r, clr_nxt;
  logic [ROW_W-1:0] rowdat_r, rowdat_nxt;
  logic [2:0]      res_status_r, res_status_nxt;
  logic [11:0]     res_page_r, res_page_nxt;
  logic [FW-1:0]   res_frame_r, res_frame_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [11:0]   out_page_r, out_page_nxt;
  logic [FW-1:0] out_frame_r, out_frame_nxt;

  // Present bitmap and entry table.
  logic [ROW_W-1:0]  bm_mem [ROWS];
  logic              bm_re, bm_we;
  logic [RW-1:0]     bm_ra, bm_wa;
  logic [ROW_W-1:0]  bm_wd, bm_q_r;
  pfa_pkg::entry_t   ft_mem [ROWS*ROW_W];
  logic              ft_re, ft_we;
  logic [PG_W-1:0]   ft_ra, ft_wa;
  pfa_pkg::entry_t   ft_wd, ft_q_r;

  pfa_pkg::stk_cmd_t  stk_cmd;
  pfa_pkg::stk_stat_t stk_stat;

  logic [ROW_W-1:0] row_eff;
  logic             fz_found;
  logic [BW-1:0]    fz_idx;
  logic [ROW_W-1:0] pg_bit;

  // Pad bits past the last page read as present so the scan never picks them.
  assign row_eff = bm_q_r | ((chk_row_r == RW'(ROWS - 1)) ? LAST_PAD : '0);
  assign pg_bit  = ROW_W'(1) << pg_r[BW-1:0];

  pfa_find_zero #(.ROW_W(ROW_W)) u_find (
    .row   (row_eff),
    .found (fz_found),
    .idx   (fz_idx)
  );

  pfa_frame_stack #(.FRAMES(FRAMES)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_frame_r, out_page_r};
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    kern_nxt       = kern_r;
    pg_nxt         = pg_r;
    frm_nxt        = frm_r;
    issue_nxt      = issue_r;
    chk_vld_nxt    = 1'b0;
    chk_row_nxt    = chk_row_r;
    clr_nxt        = clr_r;
    rowdat_nxt     = rowdat_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_frame_nxt  = res_frame_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_frame_nxt  = out_frame_r;
    bm_re = 1'b0;
    bm_ra = '0;
    bm_we = 1'b0;
    bm_wa = '0;
    bm_wd = '0;
    ft_re = 1'b0;
    ft_ra = '0;
    ft_we = 1'b0;
    ft_wa = '0;
    ft_wd = '0;
    stk_cmd = '0;

    unique case (state_r)
      S_CLEAR: begin
        bm_we   = 1'b1;
        bm_wa   = clr_r;
        clr_nxt = clr_r + RW'(1);
        if (clr_r == RW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_op;
          kern_nxt = in_kern;
          pg_nxt   = in_pg;
          frm_nxt  = in_frame;
          unique case (in_op)
            pfa_pkg::OP_ALLOC: begin
              issue_nxt = '0;
              state_nxt = S_SCAN;
            end
            pfa_pkg::OP_GIVE: begin
              stk_cmd.push   = !stk_stat.full;
              stk_cmd.wdata  = in_frame;
              res_status_nxt = stk_stat.full ? pfa_pkg::ST_FULL : pfa_pkg::ST_OK;
              res_page_nxt   = '0;
              res_frame_nxt  = in_frame;
              state_nxt      = S_RESP;
            end
            pfa_pkg::OP_FREE, pfa_pkg::OP_MAP: begin
              if (!page_ok) begin
                res_status_nxt = pfa_pkg::ST_NOT_PRESENT;
                res_page_nxt   = in_page;
                res_frame_nxt  = '0;
                state_nxt      = S_RESP;
              end else begin
                bm_re     = 1'b1;
                bm_ra     = in_pg[PG_W-1:BW];
                ft_re     = 1'b1;
                ft_ra     = in_pg;
                state_nxt = S_RMW;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Reads of the next row overlap the check of the row read last cycle.
        if (issue_r < (RW + 1)'(ROWS)) begin
          bm_re       = 1'b1;
          bm_ra       = issue_r[RW-1:0];
          issue_nxt   = issue_r + (RW + 1)'(1);
          chk_vld_nxt = 1'b1;
          chk_row_nxt = issue_r[RW-1:0];
        end
        if (chk_vld_r) begin
          if (fz_found) begin
            chk_vld_nxt = 1'b0;
            pg_nxt      = {chk_row_r, fz_idx};
            rowdat_nxt  = bm_q_r | (ROW_W'(1) << fz_idx);
            if (stk_stat.empty) begin
              res_status_nxt = pfa_pkg::ST_NO_FRAME;
              res_page_nxt   = 12'({chk_row_r, fz_idx});
              res_frame_nxt  = '0;
              state_nxt      = S_RESP;
            end else begin
              stk_cmd.rd = 1'b1;
              state_nxt  = S_POP;
            end
          end else if (chk_row_r == RW'(ROWS - 1)) begin
            chk_vld_nxt    = 1'b0;
            res_status_nxt = pfa_pkg::ST_NO_PAGE;
            res_page_nxt   = '0;
            res_frame_nxt  = '0;
            state_nxt      = S_RESP;
          end
        end
      end

      S_POP: begin
        stk_cmd.pop    = 1'b1;
        bm_we          = 1'b1;
        bm_wa          = pg_r[PG_W-1:BW];
        bm_wd          = rowdat_r;
        ft_we          = 1'b1;
        ft_wa          = pg_r;
        ft_wd.user     = !kern_r;
        ft_wd.frame    = stk_stat.rdata;
        res_status_nxt = pfa_pkg::ST_OK;
        res_page_nxt   = 12'(pg_r);
        res_frame_nxt  = stk_stat.rdata;
        state_nxt      = S_RESP;
      end

      S_RMW: begin
        res_page_nxt = 12'(pg_r);
        state_nxt    = S_RESP;
        if (op_r == pfa_pkg::OP_FREE) begin
          if (!(|(bm_q_r & pg_bit))) begin
            res_status_nxt = pfa_pkg::ST_NOT_PRESENT;
            res_frame_nxt  = '0;
          end else begin
            bm_we          = 1'b1;
            bm_wa          = pg_r[PG_W-1:BW];
            bm_wd          = bm_q_r & ~pg_bit;
            stk_cmd.push   = !stk_stat.full;
            stk_cmd.wdata  = ft_q_r.frame;
            res_status_nxt = stk_stat.full ? pfa_pkg::ST_FULL : pfa_pkg::ST_OK;
            res_frame_nxt  = ft_q_r.frame;
          end
        end else begin
          bm_we          = 1'b1;
          bm_wa          = pg_r[PG_W-1:BW];
          bm_wd          = bm_q_r | pg_bit;
          ft_we          = 1'b1;
          ft_wa          = pg_r;
          ft_wd.user     = !kern_r;
          ft_wd.frame    = frm_r;
          res_status_nxt = pfa_pkg::ST_OK;
          res_frame_nxt  = frm_r;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
          out_frame_nxt  = res_frame_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      issue_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    kern_r       <= kern_nxt;
    pg_r         <= pg_nxt;
    frm_r        <= frm_nxt;
    chk_row_r    <= chk_row_nxt;
    rowdat_r     <= rowdat_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_frame_r  <= res_frame_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_frame_r  <= out_frame_nxt;
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_wa] <= bm_wd;
    end
    if (bm_re) begin
      bm_q_r <= bm_mem[bm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ft_we) begin
      ft_mem[ft_wa] <= ft_wd;
    end
    if (ft_re) begin
      ft_q_r <= ft_mem[ft_ra];
    end
  end

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while another is in work");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.pop |-> !stk_stat.empty)
    else $error("frame popped from an empty stack");

  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result shown during the bitmap clearing pass");

endmodule
